### rtl/ddzn_pkg.sv
// Shared types, constants and the zigzag function of the depth delta encoder.
// Used by ddzn_ctrl, ddzn_dp and the top level; depends on nothing.
package ddzn_pkg;

  localparam int unsigned PixelWidth = 16;
  localparam int unsigned GroupBits  = 3;
  localparam int unsigned CodeWidth  = GroupBits + 1;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 8;

  typedef logic [PixelWidth-1:0] pixel_t;
  typedef logic [GroupBits-1:0]  group_t;
  typedef logic [CodeWidth-1:0]  code_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take a pixel, form its zigzag word
    logic emit;   // move the low group into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;   // groups remain after the current low group
  } status_t;

  // Signed difference mapped to non-negative: d >= 0 -> 2d, d < 0 -> -2d-1.
  function automatic pixel_t zigzag(input pixel_t diff);
    zigzag = {diff[PixelWidth-2:0], 1'b0} ^ {PixelWidth{diff[PixelWidth-1]}};
  endfunction

endpackage

### rtl/ddzn_dp.sv
// Datapath of the depth delta encoder: previous pixel, group shift register
// and output code register. Imports ddzn_pkg; driven by ddzn_ctrl.
module ddzn_dp
  import ddzn_pkg::*;
(
  input  logic    clk,
  input  cmd_t    cmd,
  output status_t status,
  input  pixel_t  pixel,
  input  logic    frame_start,
  input  logic    rst,
  output code_t   code,
  output logic    last
);

  pixel_t previous_pixel;
  pixel_t work;
  pixel_t diff;
  logic   more;

  assign diff = pixel - (frame_start ? '0 : previous_pixel);
  assign more = |work[PixelWidth-1:GroupBits];
  assign status.more = more;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pixel <= '0;
    end else if (cmd.load) begin
      previous_pixel <= pixel;
    end
  end

  // load wins over the shift; the group being emitted was read beforehand
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= zigzag(diff);
    end else if (cmd.emit) begin
      work <= work >> GroupBits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      code <= {more, work[GroupBits-1:0]};
      last <= ~more;
    end
  end

endmodule

### rtl/ddzn_ctrl.sv
// Controller of the depth delta encoder: pixel state machine and output
// valid flag. Imports ddzn_pkg; commands ddzn_dp.
module ddzn_ctrl
  import ddzn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = ~out_valid | out_ready;
  assign cmd.emit = (state == ST_EMIT) && out_free;
  // take the next pixel in the cycle the final group leaves
  assign in_ready = (state == ST_IDLE) || (cmd.emit && ~status.more);
  assign cmd.load = in_valid && in_ready;

  always_comb begin
    state_next = state;
    if (cmd.load) begin
      state_next = ST_EMIT;
    end else if (cmd.emit && ~status.more) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_enters_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_EMIT)
    else $error("pixel load did not start emission");

  a_more_stays: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.more |=> state == ST_EMIT && out_valid)
    else $error("left emission with groups pending");

  a_ready_only_at_end: assert property (@(posedge clk) disable iff (rst)
    in_ready && state == ST_EMIT |-> cmd.emit && !status.more)
    else $error("ready raised mid pixel");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted code not presented");

endmodule

### rtl/depth_delta_zigzag_nibble_encoder.sv
// Top level of the depth delta / zigzag / 3-bit group encoder.
// Imports ddzn_pkg; instantiates ddzn_ctrl and ddzn_dp.
//
//  channel  dir  tdata (low bit up)           tuser          tlast
//  s_axis   in   [15:0] pixel                  frame_start    -
//  m_axis   out  [3:0] code, [7:4] zero        -              last
//
// A pixel yields 1 to 6 codes, sent by the single group shift register at
// one 3-bit group per cycle while the output is not stalled.
// The next pixel is taken in the cycle its predecessor's final code leaves.
// Reset (rst, synchronous) clears the previous pixel, the state machine and
// the output valid flag.
// A stalled output holds its code; emission pauses until it is taken.
module depth_delta_zigzag_nibble_encoder
  import ddzn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [15:0] pixel
  input  logic                s_axis_tuser,   // [0] frame_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [3:0] code, [7:4] zero
  output logic                m_axis_tlast
);

  cmd_t    cmd;
  status_t status;
  code_t   code;

  ddzn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  ddzn_dp u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .pixel       (s_axis_tdata[PixelWidth-1:0]),
    .frame_start (s_axis_tuser),
    .rst         (rst),
    .code        (code),
    .last        (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OutDataW-CodeWidth){1'b0}}, code};

endmodule
